@@ design/red_pkg.sv @@
// Shared types, constants and command codes for the rounded Euclidean distance row block.
package red_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;
    localparam int ROW_LIMIT = 64;
    localparam logic [6:0] COUNT_RESET = 7'd64;
    localparam logic [16:0] DIST_MAX = 17'd131071;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ROW = 2'd1;
    localparam logic [1:0] CMD_ERR = 2'd2;

    typedef struct packed {
        logic              action;
        logic [5:0]        point_index;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [5:0]        customer;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  column;
        logic        to_depot;
        logic [16:0] distance;
        logic        status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [5:0]         index;
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic [5:0]         last_target;
    } cmd_t;

endpackage

@@ design/red_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module red_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/red_front.sv @@
// Front end: point count register, range checks and a two-entry command queue.
module red_front import red_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  in_item_t item,
    input  logic     count_we,
    input  logic [6:0] count_wdata,
    output logic     cmd_valid,
    output cmd_t     cmd,
    input  logic     cmd_pop
);

    localparam int LIMIT = (MAX_POINTS < ROW_LIMIT) ? MAX_POINTS : ROW_LIMIT;

    logic [6:0] count_reg;
    logic [1:0] fill_reg;
    logic       wptr_reg;
    logic       rptr_reg;
    cmd_t       queue_reg [2];
    logic [6:0] eff_count;
    logic       push;
    cmd_t       new_cmd;

    assign eff_count = (count_reg > 7'(LIMIT)) ? 7'(LIMIT) : count_reg;
    assign busy = (fill_reg == 2'd2);
    assign push = start && !busy;
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd = queue_reg[rptr_reg];

    always_comb
    begin
        new_cmd.index = item.point_index;
        new_cmd.x_coord = item.x_coord;
        new_cmd.y_coord = item.y_coord;
        new_cmd.last_target = 6'(eff_count - 7'd1);
        if (item.action)
        begin
            new_cmd.index = item.customer;
            new_cmd.kind = (({1'b0, item.customer} + 7'd1) < eff_count) ? CMD_ROW : CMD_ERR;
        end
        else
        begin
            new_cmd.kind = ({1'b0, item.point_index} < eff_count) ? CMD_LOAD : CMD_ERR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            fill_reg <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end
        else
        begin
            if (count_we)
            begin
                count_reg <= count_wdata;
            end
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (cmd_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(cmd_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wptr_reg] <= new_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> fill_reg != 2'd0)
        else $error("pop from empty command queue");
    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cmd_pop) |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("queue fill count lost a push");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd0 || fill_reg == 2'd2) |-> wptr_reg == rptr_reg)
        else $error("queue pointers disagree with fill count");
`endif

endmodule

@@ design/red_back.sv @@
// Back end: point memory, distance datapath with bit-serial square root, result register.
module red_back import red_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output result_t result,
    output logic    result_valid
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CB = COORD_BITS;
    localparam int MW = CB + 1;
    localparam int SW = 2 * MW;
    localparam int NSTEP = SW / 2;
    localparam int STW = $clog2(NSTEP + 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDA = 4'd1;
    localparam logic [3:0] ST_LATA = 4'd2;
    localparam logic [3:0] ST_DIFF = 4'd3;
    localparam logic [3:0] ST_SQX = 4'd4;
    localparam logic [3:0] ST_SQY = 4'd5;
    localparam logic [3:0] ST_SUM = 4'd6;
    localparam logic [3:0] ST_ISQ = 4'd7;
    localparam logic [3:0] ST_EMIT = 4'd8;
    localparam logic [3:0] ST_RDB = 4'd9;

    logic [3:0]     state_reg;
    logic [3:0]     state_next;
    logic [5:0]     cust_reg;
    logic [5:0]     last_reg;
    logic [5:0]     t_reg;
    logic [CB-1:0]  ax_reg;
    logic [CB-1:0]  ay_reg;
    logic [MW-1:0]  dx_reg;
    logic [MW-1:0]  dy_reg;
    logic [SW-1:0]  p1_reg;
    logic [SW-1:0]  p2_reg;
    logic [SW-1:0]  rem_reg;
    logic [SW-1:0]  root_reg;
    logic [SW-1:0]  bit_reg;
    logic [STW-1:0] step_reg;
    result_t        res_reg;
    logic           res_valid_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [2*CB-1:0] ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [2*CB-1:0] ram_rdata;

    logic [MW-1:0] diff_x;
    logic [MW-1:0] diff_y;
    logic [SW-1:0] sq_x;
    logic [SW-1:0] sq_y;
    logic [SW-1:0] trial;
    logic [SW-1:0] rounded;
    logic [16:0]   dist_sat;

    red_ram #(.WIDTH(2 * CB), .DEPTH(MAX_POINTS)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    assign ram_we = cmd_pop && (cmd.kind == CMD_LOAD);
    assign ram_waddr = AW'(cmd.index);
    assign ram_wdata = {CB'(cmd.x_coord), CB'(cmd.y_coord)};
    assign ram_raddr = (state_reg == ST_RDA) ? AW'(cust_reg + 6'd1) : AW'(t_reg);

    assign diff_x = {ax_reg[CB-1], ax_reg}
                  - {ram_rdata[2*CB-1], ram_rdata[2*CB-1:CB]};
    assign diff_y = {ay_reg[CB-1], ay_reg} - {ram_rdata[CB-1], ram_rdata[CB-1:0]};
    assign sq_x = dx_reg * dx_reg;
    assign sq_y = dy_reg * dy_reg;
    assign trial = root_reg + bit_reg;
    assign rounded = root_reg + SW'(rem_reg > root_reg);
    assign dist_sat = (rounded > SW'(DIST_MAX)) ? DIST_MAX : rounded[16:0];
    assign result = res_reg;
    assign result_valid = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_pop && cmd.kind == CMD_ROW)
                begin
                    state_next = ST_RDA;
                end
            end
            ST_RDA:  state_next = ST_LATA;
            ST_LATA: state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQX;
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_ISQ;
            ST_ISQ:
            begin
                if (step_reg == STW'(NSTEP - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: state_next = (t_reg == last_reg) ? ST_IDLE : ST_RDB;
            ST_RDB:  state_next = ST_DIFF;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid_reg <= (cmd_pop && cmd.kind != CMD_ROW) || (state_reg == ST_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cust_reg <= cmd.index;
                last_reg <= cmd.last_target;
                t_reg <= 6'd0;
                res_reg.column <= 6'd0;
                res_reg.to_depot <= 1'b0;
                res_reg.distance <= 17'd0;
                res_reg.status <= (cmd.kind == CMD_ERR);
                res_reg.last <= 1'b1;
            end
            ST_LATA:
            begin
                ax_reg <= ram_rdata[2*CB-1:CB];
                ay_reg <= ram_rdata[CB-1:0];
            end
            ST_DIFF:
            begin
                dx_reg <= diff_x[MW-1] ? -diff_x : diff_x;
                dy_reg <= diff_y[MW-1] ? -diff_y : diff_y;
            end
            ST_SQX: p1_reg <= sq_x;
            ST_SQY: p2_reg <= sq_y;
            ST_SUM:
            begin
                rem_reg <= p1_reg + p2_reg;
                root_reg <= '0;
                bit_reg <= SW'(1) << (SW - 2);
                step_reg <= '0;
            end
            ST_ISQ:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                step_reg <= step_reg + STW'(1);
            end
            ST_EMIT:
            begin
                res_reg.column <= (t_reg == 6'd0) ? 6'd0 : t_reg - 6'd1;
                res_reg.to_depot <= (t_reg == 6'd0);
                res_reg.distance <= dist_sat;
                res_reg.status <= 1'b0;
                res_reg.last <= (t_reg == last_reg);
                t_reg <= t_reg + 6'd1;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_no_result_mid_root: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISQ) |=> !res_valid_reg)
        else $error("result strobe during square root");
    a_write_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_IDLE)
        else $error("point memory written during a row");
    a_target_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> t_reg <= last_reg)
        else $error("row target past last column");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISQ) |-> step_reg < STW'(NSTEP))
        else $error("square root ran too many steps");
`endif

endmodule

@@ design/rounded_euclidean_distance_rows_top.sv @@
// Top level of the rounded Euclidean distance row block.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------
//  command   | start / busy           | item (in_item_t)
//  result    | result_valid strobe    | result (result_t)
//  config    | count_we               | count_wdata (point count)
//
// A load transaction or a rejected transaction gives one registered result once the
// back end takes it from the command queue. A row transaction gives one result per
// point in use; each distance comes from the bit-serial square root unit, which
// retires one result bit per cycle. Reset clears the point count to 64 and empties
// the command queue; the point memory is not cleared and must be loaded before rows
// are requested. The receiver cannot stall: each result is on the ports for exactly
// one cycle. The two-entry command queue lets start accept up to two commands while
// a row is being computed.
module rounded_euclidean_distance_rows_top import red_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_item_t   item,
    input  logic       count_we,
    input  logic [6:0] count_wdata,
    output result_t    result,
    output logic       result_valid
);

    // Commands cross from the classifier to the datapath through the queue.
    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    red_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .count_we    (count_we),
        .count_wdata (count_wdata),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    // The back end owns the point memory, so loads stay ordered behind rows.
    red_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

@@ tb/tb_rounded_euclidean_distance_rows_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the rounded Euclidean distance row block.
module tb_rounded_euclidean_distance_rows_top import red_pkg::*; ();

    localparam int HALF_PERIOD = 6;

    logic       clk;
    logic       rst_n;
    logic       start = 1'b0;
    logic       busy;
    in_item_t   item = '0;
    logic       count_we;
    logic [6:0] count_wdata;
    result_t    result;
    logic       result_valid;

    rounded_euclidean_distance_rows_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .count_we     (count_we),
        .count_wdata  (count_wdata),
        .result       (result),
        .result_valid (result_valid)
    );

    // Predictor state: a private copy of the coordinate memory and the point count.
    logic signed [15:0] coord_x [0:63];
    logic signed [15:0] coord_y [0:63];
    logic [6:0]         points_in_use;

    in_item_t pending_cmds [$];
    result_t  expected_results [$];

    int mismatch_count = 0;
    int result_count = 0;
    int row_count = 0;
    int load_count = 0;
    int error_count = 0;
    int drive_gap = 0;

    // Busy as seen at the last rising edge.
    logic busy_at_edge;

    always #HALF_PERIOD clk = ~clk;

    // Appends a command to the driver's list.
    task automatic add_cmd(in_item_t c);
        pending_cmds = {pending_cmds, c};
    endtask

    // Appends one expected result to the scoreboard.
    task automatic add_expect(result_t r);
        expected_results = {expected_results, r};
    endtask

    // Rounded distance between two stored points, done in plain integer arithmetic.
    function automatic logic [16:0] rounded_distance(int a, int b);
        longint dx;
        longint dy;
        longint sum;
        longint root;
        longint lo;
        longint hi;
        longint mid;
        dx = longint'(coord_x[a]) - longint'(coord_x[b]);
        dy = longint'(coord_y[a]) - longint'(coord_y[b]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sum = dx * dx + dy * dy;
        lo = 0;
        hi = 131072;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= sum) lo = mid;
            else hi = mid - 1;
        end
        root = lo;
        if (sum > root * root + root) root = root + 1;
        if (root > 131071) root = 131071;
        return root[16:0];
    endfunction

    // Applies one accepted transaction to the predictor and queues its results.
    task automatic predict_results(in_item_t cmd);
        result_t r;
        int      n;
        int      ncust;
        n = (points_in_use > 64) ? 64 : points_in_use;
        ncust = (n > 0) ? n - 1 : 0;
        r = '0;
        r.last = 1'b1;
        if (cmd.action == 1'b0) begin
            if (cmd.point_index >= n) begin
                r.status = 1'b1;
                error_count++;
            end else begin
                coord_x[cmd.point_index] = cmd.x_coord;
                coord_y[cmd.point_index] = cmd.y_coord;
                load_count++;
            end
            add_expect(r);
        end else if (cmd.customer >= ncust) begin
            r.status = 1'b1;
            error_count++;
            add_expect(r);
        end else begin
            row_count++;
            r.to_depot = 1'b1;
            r.distance = rounded_distance(0, cmd.customer + 1);
            r.last = (ncust == 0);
            add_expect(r);
            for (int d = 0; d < ncust; d++) begin
                r = '0;
                r.column = d[5:0];
                r.distance = rounded_distance(cmd.customer + 1, d + 1);
                r.last = (d + 1 == ncust);
                add_expect(r);
            end
        end
    endtask

    // Driver: presents queued commands at the falling edge with random gaps.
    // The predictor runs at the accepting rising edge, so queue order matches the block.
    always @(negedge clk) begin
        if (rst_n) begin
            if (start && !busy_at_edge) begin
                // The previous command went in at the last rising edge.
                start <= 1'b0;
                drive_gap = $urandom_range(0, 6);
                if (($urandom_range(0, 3) == 0)) drive_gap = 0;
            end else if (!start) begin
                if (drive_gap > 0) begin
                    drive_gap--;
                end else if (pending_cmds.size() > 0) begin
                    item  <= pending_cmds.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    // Acceptance seen at the rising edge.
    always @(posedge clk) begin
        busy_at_edge <= busy;
        if (rst_n && start && !busy)
            predict_results(item);
    end

    // Monitor: compares every strobed result with the oldest expectation.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_valid) begin
            result_count++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result %p", result);
            end else begin
                want = expected_results.pop_front();
                if (result !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result mismatch expected %p actual %p", want, result);
                end
            end
        end
    end

    // Builds a load command for one slot.
    function automatic in_item_t make_load(int idx, int x, int y);
        in_item_t c;
        c = '0;
        c.action = 1'b0;
        c.point_index = idx[5:0];
        c.x_coord = x[15:0];
        c.y_coord = y[15:0];
        c.customer = 6'($urandom_range(0, 63));
        return c;
    endfunction

    function automatic in_item_t make_row(int cust);
        in_item_t c;
        c = '0;
        c.action = 1'b1;
        c.customer = cust[5:0];
        c.point_index = 6'($urandom_range(0, 63));
        c.x_coord = 16'($urandom);
        c.y_coord = 16'($urandom);
        return c;
    endfunction

    // Waits until every queued command has gone in and every result has arrived.
    task automatic drain();
        while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (1700) @(posedge clk);
    endtask

    // Writes the point count while the block is idle.
    task automatic write_count(int value);
        @(negedge clk);
        count_we <= 1'b1;
        count_wdata <= value[6:0];
        @(negedge clk);
        count_we <= 1'b0;
        points_in_use = value[6:0];
    endtask

    // Loads every slot in use with random or extreme coordinates, so rows never read unwritten slots.
    task automatic queue_full_load(int n, bit extremes);
        for (int i = 0; i < n; i++) begin
            if (extremes)
                add_cmd(make_load(i, (i % 2) ? 32767 : -32768,
                                     (i % 3) ? -32768 : 32767));
            else
                add_cmd(make_load(i, $urandom, $urandom));
        end
    endtask

    initial begin
        int counts [5];
        int n;
        int k;
        clk = 1'b0;
        rst_n = 1'b0;
        count_we = 1'b0;
        count_wdata = '0;
        points_in_use = COUNT_RESET;
        for (int i = 0; i < 64; i++) begin
            coord_x[i] = '0;
            coord_y[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at a count of three: opposite corners give the largest
        // distance, a zero-offset pair gives zero, and out-of-range requests follow.
        write_count(3);
        add_cmd(make_load(0, -32768, -32768));
        add_cmd(make_load(1, 32767, 32767));
        add_cmd(make_load(2, -32768, -32768));
        add_cmd(make_row(0));
        add_cmd(make_row(1));
        add_cmd(make_row(2));
        add_cmd(make_row(63));
        add_cmd(make_load(3, 5, 5));
        add_cmd(make_load(63, 5, 5));
        add_cmd(make_load(1, 1, 1));
        add_cmd(make_load(2, 2, 1));
        add_cmd(make_row(0));
        add_cmd(make_load(0, 0, 0));
        add_cmd(make_row(1));
        drain();

        // A count of one leaves no customers; a count of zero rejects loads too.
        write_count(1);
        add_cmd(make_load(0, 7, -7));
        add_cmd(make_load(1, 7, -7));
        add_cmd(make_row(0));
        drain();
        write_count(0);
        add_cmd(make_load(0, 3, 3));
        add_cmd(make_row(0));
        drain();

        // Random phases over several counts, the extremes among them.
        counts = '{2, 64, 9, 127, 5};
        for (int p = 0; p < 5; p++) begin
            write_count(counts[p]);
            n = (counts[p] > 64) ? 64 : counts[p];
            queue_full_load(n, p == 1);
            k = (n > 16) ? 6 : 52;
            for (int j = 0; j < k; j++) begin
                case ($urandom_range(0, 9))
                    0: add_cmd(make_load($urandom_range(0, 63), $urandom, $urandom));
                    1: add_cmd(make_row($urandom_range(0, 63)));
                    2, 3: add_cmd(make_load($urandom_range(0, n - 1), $urandom, $urandom));
                    default: add_cmd(make_row($urandom_range(0, n - 2)));
                endcase
            end
            drain();
        end

        $display("Run covered %0d loads, %0d rows and %0d rejected transactions,",
                 load_count, row_count, error_count);
        $display("%0d results checked over point counts 0 through 127.", result_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #60ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
design/red_pkg.sv
design/red_ram.sv
design/red_front.sv
design/red_back.sv
design/rounded_euclidean_distance_rows_top.sv
tb/tb_rounded_euclidean_distance_rows_top.sv
